// ===== hdl/lks_pkg.sv =====
// Shared types and codes for the LRU key set.
// No dependencies; used by every module of the block.
package lks_pkg;

    localparam logic MODE_PUT = 1'b0;
    localparam logic MODE_HAS = 1'b1;

    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;

    typedef struct packed {
        logic take;
        logic hit;
        logic fill;
        logic evict;
    } op_t;

endpackage

// ===== hdl/lru_key_set_top.sv =====
// Top level of the LRU key set: chain of lks_cell entries plus control.
// Depends on lks_pkg and lks_cell.
//
// Usage:
//   Input channel s_valid/s_ready carries one word: s_mode (put or has) and
//   s_key. Result channel m_valid/m_ready returns one word per input word:
//   m_answer (put: 1 if newly inserted; has: 1 if present).
//   A word accepted at an edge shows its answer on m_answer right after
//   that edge. Throughput is one word per cycle unless m_ready stalls the
//   output register; the whole chain compares the key and shifts in the same
//   cycle, and that compare-and-shift path sets the clock limit.
//   The chain keeps entries ordered by recency: cell 0 is most recent.
//   A stalled receiver holds the answer in the output register; a new word
//   is still taken while that register is emptied in the same cycle.
//   cfg_wen/cfg_wdata write the capacity register (0 acts as 1, values
//   above DEPTH act as DEPTH); write it only while the block is idle.
//   Synchronous active-low reset empties the set, drops any pending answer
//   and sets capacity to 16. No clearing pass is needed.
module lru_key_set_top #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wen,
    input  logic [lks_pkg::CAP_W-1:0]    cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [KEY_WIDTH-1:0]         s_key,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_answer
);

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (OCC_W > lks_pkg::CAP_W) ? OCC_W : lks_pkg::CAP_W;

    logic [lks_pkg::CAP_W-1:0] cap_reg;
    logic [OCC_W-1:0]          occ_reg;
    logic [OCC_W-1:0]          occ_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic                      m_answer_reg;
    logic                      m_answer_next;

    logic [KEY_WIDTH-1:0] key_chain   [0:DEPTH];
    logic                 valid_chain [0:DEPTH];
    logic                 hit_chain   [0:DEPTH];
    logic [DEPTH-1:0]     hit_vec;

    logic [CMP_W-1:0] cap_eff;
    logic             full;
    logic             hit_any;
    logic             take;
    logic             is_put;
    lks_pkg::op_t     op;

    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign is_put  = (s_mode == lks_pkg::MODE_PUT);

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CMP_W'(1);
        end else if (CMP_W'(cap_reg) > CMP_W'(DEPTH)) begin
            cap_eff = CMP_W'(DEPTH);
        end else begin
            cap_eff = CMP_W'(cap_reg);
        end
    end

    assign full    = CMP_W'(occ_reg) >= cap_eff;
    assign hit_any = hit_chain[0];

    assign op.take  = take;
    assign op.hit   = hit_any;
    assign op.fill  = is_put && !hit_any && !full;
    assign op.evict = is_put && !hit_any && full;

    assign key_chain[0]       = s_key;
    assign valid_chain[0]     = 1'b1;
    assign hit_chain[DEPTH]   = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        lks_cell #(
            .KEY_WIDTH(KEY_WIDTH)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .op          (op),
            .cmp_key     (s_key),
            .up_key      (key_chain[i]),
            .up_valid    (valid_chain[i]),
            .hit_below_in(hit_chain[i+1]),
            .hit_ge_out  (hit_chain[i]),
            .hit_here    (hit_vec[i]),
            .key_out     (key_chain[i+1]),
            .valid_out   (valid_chain[i+1])
        );
    end

    always_comb begin
        occ_next = occ_reg;
        if (take && op.fill) begin
            occ_next = occ_reg + OCC_W'(1);
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_answer_next = m_answer_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (take) begin
            m_valid_next  = 1'b1;
            m_answer_next = is_put ? !(|hit_vec) : (|hit_vec);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= lks_pkg::CAP_W'(lks_pkg::CAP_RESET);
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                cap_reg <= cfg_wdata;
            end
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_answer_reg <= m_answer_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_answer = m_answer_reg;

endmodule

// ===== hdl/lks_cell.sv =====
// One entry of the recency-ordered chain: key and valid bit.
// Depends on lks_pkg (op_t).
module lks_cell #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lks_pkg::op_t         op,
    input  logic [KEY_WIDTH-1:0] cmp_key,
    input  logic [KEY_WIDTH-1:0] up_key,
    input  logic                 up_valid,
    input  logic                 hit_below_in,
    output logic                 hit_ge_out,
    output logic                 hit_here,
    output logic [KEY_WIDTH-1:0] key_out,
    output logic                 valid_out
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic                 valid_reg;
    logic                 shift;

    assign hit_here   = valid_reg && (key_reg == cmp_key);
    assign hit_ge_out = hit_here | hit_below_in;

    always_comb begin
        shift = 1'b0;
        if (op.take) begin
            if (op.hit) begin
                shift = hit_ge_out;
            end else if (op.fill) begin
                shift = up_valid;
            end else if (op.evict) begin
                shift = valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            key_reg <= up_key;
        end
    end

    assign key_out   = key_reg;
    assign valid_out = valid_reg;

endmodule

// ===== hdl/lks_checker.sv =====
// Port-level checks for lru_key_set_top, attached with a bind.
// Depends on lks_pkg (mode codes).
module lks_checker #(
    parameter int KEY_WIDTH = 32
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 s_mode,
    input logic [KEY_WIDTH-1:0] s_key,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_answer
);

    logic s_acc;
    assign s_acc = s_valid && s_ready;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_answer))
        else $error("result word changed while stalled");

    a_answer_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> m_valid)
        else $error("no result word after accepted word");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word pending after reset");

    a_put_then_has: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_mode == lks_pkg::MODE_PUT) ##1
        (s_acc && s_mode == lks_pkg::MODE_HAS && s_key == $past(s_key))
        |=> m_answer)
        else $error("key just put reported absent");

    a_put_twice: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_mode == lks_pkg::MODE_PUT) ##1
        (s_acc && s_mode == lks_pkg::MODE_PUT && s_key == $past(s_key))
        |=> !m_answer)
        else $error("key just put inserted again");

endmodule

bind lru_key_set_top lks_checker #(
    .KEY_WIDTH(KEY_WIDTH)
) u_lks_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_mode  (s_mode),
    .s_key   (s_key),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_answer(m_answer)
);

// ===== bench/testbench.sv =====
// Self-checking bench for lru_key_set_top: put/has words over valid-ready channels.
// A directed table comes first, then random phases checked against an LRU set predictor.
// Depends on lks_pkg and the lru_key_set_top RTL.
module testbench;

    localparam int DEPTH       = 16;
    localparam int KEY_W       = 32;
    localparam int LIMIT       = 400000;
    localparam int HOLD_CYCLES = 100;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 190;
    localparam int POOL_MAX    = 24;
    localparam int NO_TYPED    = -1;

    typedef enum logic {ROW_WORD, ROW_CAP} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic             md;
        logic [KEY_W-1:0] k;
        int               want;
    } plan_row_t;

    typedef struct {
        logic             answer;
        logic             md;
        logic [KEY_W-1:0] k;
    } answer_exp_t;

    localparam int PLAN_LEN = 25;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{ROW_WORD, lks_pkg::MODE_HAS, 32'h0000_0000, 0},
        '{ROW_WORD, lks_pkg::MODE_PUT, 32'h0000_0000, 1},
        '{ROW_WORD, lks_pkg::MODE_PUT, 32'h0000_0000, 0},
        '{ROW_WORD, lks_pkg::MODE_HAS, 32'h0000_0000, 1},
        '{ROW_WORD, lks_pkg::MODE_PUT, 32'hFFFF_FFFF, 1},
        '{ROW_WORD, lks_pkg::MODE_HAS, 32'hFFFF_FFFF, 1},
        '{ROW_WORD, lks_pkg::MODE_HAS, 32'h0000_0001, 0},
        '{ROW_CAP,  lks_pkg::MODE_PUT, 32'd1,         NO_TYPED},
        '{ROW_WORD, lks_pkg::MODE_PUT, 32'h0000_0005, 1},
        '{ROW_WORD, lks_pkg::MODE_HAS, 32'h0000_0000, 0},
        '{ROW_WORD, lks_pkg::MODE_HAS, 32'hFFFF_FFFF, 1},
        '{ROW_CAP,  lks_pkg::MODE_PUT, 32'd0,         NO_TYPED},
        '{ROW_WORD, lks_pkg::MODE_PUT, 32'h0000_0007, 1},
        '{ROW_WORD, lks_pkg::MODE_HAS, 32'h0000_0005, 0},
        '{ROW_WORD, lks_pkg::MODE_HAS, 32'hFFFF_FFFF, NO_TYPED},
        '{ROW_CAP,  lks_pkg::MODE_PUT, 32'd31,        NO_TYPED},
        '{ROW_WORD, lks_pkg::MODE_PUT, 32'h8000_0000, 1},
        '{ROW_WORD, lks_pkg::MODE_PUT, 32'h5555_5555, 1},
        '{ROW_WORD, lks_pkg::MODE_PUT, 32'hAAAA_AAAA, 1},
        '{ROW_WORD, lks_pkg::MODE_HAS, 32'h0000_0007, NO_TYPED},
        '{ROW_WORD, lks_pkg::MODE_PUT, 32'h7FFF_FFFF, 1},
        '{ROW_WORD, lks_pkg::MODE_HAS, 32'h8000_0000, NO_TYPED},
        '{ROW_WORD, lks_pkg::MODE_PUT, 32'h0000_0007, NO_TYPED},
        '{ROW_WORD, lks_pkg::MODE_HAS, 32'h0000_0001, 0},
        '{ROW_WORD, lks_pkg::MODE_PUT, 32'h0000_0001, 1}
    };

    logic                      aclk;
    logic                      aresetn   = 1'b0;
    logic                      cfg_wen   = 1'b0;
    logic [lks_pkg::CAP_W-1:0] cfg_wdata = '0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    logic                      s_mode    = lks_pkg::MODE_PUT;
    logic [KEY_W-1:0]          s_key     = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    logic                      m_answer;

    lru_key_set_top #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_W)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_key     (s_key),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_answer  (m_answer)
    );

    // predictor state
    logic [KEY_W-1:0]          slot_key  [DEPTH];
    logic                      slot_used [DEPTH];
    int                        slot_age  [DEPTH];
    int                        fill_count;
    logic [lks_pkg::CAP_W-1:0] cap_setting;

    answer_exp_t pending_answers [$];
    int          typed_answers [$];
    int          words_sent   = 0;
    int          answers_seen = 0;
    int          failures     = 0;
    int          hits_seen    = 0;
    int          evictions    = 0;
    int          caps_used    = 0;
    int          cycles       = 0;
    int          holds_asked  = 0;
    int          holds_done   = 0;
    int          burst_left   = 0;
    bit          offering     = 1'b0;
    logic [KEY_W-1:0] key_pool [POOL_MAX];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d answers seen",
                     cycles, answers_seen, words_sent);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void promote(input int idx);
        int r;
        r = slot_age[idx];
        for (int j = 0; j < DEPTH; j++)
            if (slot_used[j] && slot_age[j] < r)
                slot_age[j]++;
        slot_age[idx] = 0;
    endfunction

    function automatic logic predict_answer(input logic md, input logic [KEY_W-1:0] k);
        int hit, slot, lim, oldest_age;
        hit = -1;
        slot = -1;
        for (int i = 0; i < DEPTH; i++)
            if (hit < 0 && slot_used[i] && slot_key[i] == k)
                hit = i;
        if (hit >= 0) begin
            promote(hit);
            hits_seen++;
            return (md == lks_pkg::MODE_HAS);
        end
        if (md == lks_pkg::MODE_HAS)
            return 1'b0;
        lim = (cap_setting == 0) ? 1 : (cap_setting > DEPTH) ? DEPTH : int'(cap_setting);
        if (fill_count < lim)
            for (int i = 0; i < DEPTH; i++)
                if (slot < 0 && !slot_used[i])
                    slot = i;
        if (slot >= 0) begin
            for (int j = 0; j < DEPTH; j++)
                if (slot_used[j])
                    slot_age[j]++;
            slot_key[slot]  = k;
            slot_used[slot] = 1'b1;
            slot_age[slot]  = 0;
            fill_count++;
        end else begin
            oldest_age = 0;
            for (int i = 0; i < DEPTH; i++)
                if (slot_used[i] && (slot < 0 || slot_age[i] > oldest_age)) begin
                    slot = i;
                    oldest_age = slot_age[i];
                end
            if (slot >= 0) begin
                slot_key[slot] = k;
                promote(slot);
                evictions++;
            end
        end
        return 1'b1;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endtask

    // accepted words feed the predictor, accepted answers are checked in order
    always @(posedge aclk) begin : watch_ports
        answer_exp_t e;
        int want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                e.md = s_mode;
                e.k = s_key;
                e.answer = predict_answer(s_mode, s_key);
                if (typed_answers.size() != 0) begin
                    want = typed_answers[0];
                    typed_answers.delete(0);
                end else begin
                    want = NO_TYPED;
                end
                if (want != NO_TYPED)
                    e.answer = want[0];
                pending_answers.push_back(e);
            end
            if (m_valid && m_ready) begin
                answers_seen++;
                if (pending_answers.size() == 0) begin
                    note_failure($sformatf("unexpected answer %0d with nothing pending",
                                           m_answer));
                end else begin
                    e = pending_answers[0];
                    pending_answers.delete(0);
                    if (m_answer !== e.answer)
                        note_failure($sformatf(
                            "answer mismatch for %s key %h: expected %0d, got %0d",
                            (e.md == lks_pkg::MODE_HAS) ? "has" : "put", e.k, e.answer,
                            m_answer));
                end
            end
        end
    end

    // receiver: random stall segments, plus long hold-offs on request
    always @(posedge aclk) begin : drive_ready
        int seg_left;
        int seg_style;
        int hold_left;
        if (hold_left == 0 && holds_done != holds_asked) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (seg_left <= 0) begin
                seg_left  = $urandom_range(1, 40);
                seg_style = $urandom_range(0, 2);
            end
            seg_left--;
            case (seg_style)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    task automatic lower_valid();
        if (offering) begin
            s_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic offer(input logic md, input logic [KEY_W-1:0] k, input int want);
        if (burst_left == 0) begin
            lower_valid();
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        typed_answers.push_back(want);
        s_valid <= 1'b1;
        offering = 1'b1;
        s_mode  <= md;
        s_key   <= k;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic drain();
        lower_valid();
        while (answers_seen != words_sent) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [lks_pkg::CAP_W-1:0] value);
        drain();
        cfg_wen     <= 1'b1;
        cfg_wdata   <= value;
        cap_setting = value;
        caps_used++;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    initial begin : stimulus
        logic [lks_pkg::CAP_W-1:0] phase_cap;
        logic                      md;
        logic [KEY_W-1:0]          k;
        int                        pool_n;
        for (int i = 0; i < DEPTH; i++) begin
            slot_used[i] = 1'b0;
            slot_age[i]  = 0;
            slot_key[i]  = '0;
        end
        fill_count  = 0;
        cap_setting = lks_pkg::CAP_W'(lks_pkg::CAP_RESET);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].kind == ROW_CAP)
                set_capacity(PLAN[i].k[lks_pkg::CAP_W-1:0]);
            else
                offer(PLAN[i].md, PLAN[i].k, PLAN[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: phase_cap = 5'd16;
                1: phase_cap = 5'd1;
                2: phase_cap = 5'd0;
                3: phase_cap = 5'd31;
                4: phase_cap = 5'd2;
                5: phase_cap = 5'd8;
                6: phase_cap = 5'd15;
                7: phase_cap = 5'd17;
                default: phase_cap = lks_pkg::CAP_W'($urandom_range(0, 31));
            endcase
            set_capacity(phase_cap);
            pool_n = $urandom_range(2, POOL_MAX);
            for (int i = 0; i < pool_n; i++)
                key_pool[i] = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom_range(0, 31))
                                                          : $urandom;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n == 60)
                    holds_asked++;
                if (n == 130)
                    drain();
                md = ($urandom_range(0, 99) < 45) ? lks_pkg::MODE_HAS : lks_pkg::MODE_PUT;
                k  = ($urandom_range(0, 9) == 0) ? $urandom
                                                 : key_pool[$urandom_range(0, pool_n - 1)];
                offer(md, k, NO_TYPED);
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (pending_answers.size() != 0)
            note_failure($sformatf("%0d answers never arrived", pending_answers.size()));
        $display("covered %0d words: %0d hits, %0d evictions, %0d capacity writes",
                 words_sent, hits_seen, evictions, caps_used);
        $display("%0d failures in %0d cycles", failures, cycles);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lks_pkg.sv
hdl/lks_cell.sv
hdl/lru_key_set_top.sv
hdl/lks_checker.sv
bench/testbench.sv
